FILE: hdl/tgi_pkg.sv
package tgi_pkg;

    localparam int POINTS_X_DEF = 32;
    localparam int POINTS_Y_DEF = 32;
    localparam int POINTS_Z_DEF = 32;
    localparam int NUM_VARS_DEF = 8;

    localparam int STORE_AW    = 18;
    localparam int STORE_DEPTH = 1 << STORE_AW;
    localparam int DATA_W      = 32;
    localparam int VAR_W       = 3;
    localparam int FRAC_W      = 16;
    localparam int WGT_W       = FRAC_W + 1;
    localparam int CFG_INDEX_W = 3;
    localparam int PROD_W      = DATA_W + 1 + WGT_W + 1;

    localparam logic [CFG_INDEX_W-1:0] REG_X_LOW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_X_HIGH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_Y_LOW  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_Y_HIGH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_Z_LOW  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_Z_HIGH = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_APPEND = 3'd6;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_OOB = 1'b1;

    localparam logic signed [DATA_W-1:0] BOUND_LOW_RST  = -32'sd205887;
    localparam logic signed [DATA_W-1:0] BOUND_HIGH_RST = 32'sd205887;

    typedef struct packed {
        logic             status;
        logic [VAR_W-1:0] var_index;
        logic             last;
        logic             zero;
    } meta_t;

    function automatic logic signed [PROD_W-1:0] lerp_mul(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b,
        input logic        [WGT_W-1:0]  w
    );
        logic signed [DATA_W:0]  d;
        logic signed [WGT_W:0]   ws;
        d  = (DATA_W+1)'(b) - (DATA_W+1)'(a);
        ws = {1'b0, w};
        return PROD_W'(d) * PROD_W'(ws);
    endfunction

    function automatic logic signed [DATA_W-1:0] lerp_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] s;
        s = (p + PROD_W'(32768)) >>> FRAC_W;
        s = s + PROD_W'(a);
        return s[DATA_W-1:0];
    endfunction

endpackage

FILE: hdl/tgi_in_if.sv
interface tgi_in_if;
    import tgi_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic [STORE_AW-1:0]      grid_address;
    logic signed [DATA_W-1:0] grid_value;
    logic signed [DATA_W-1:0] query_x;
    logic signed [DATA_W-1:0] query_y;
    logic signed [DATA_W-1:0] query_z;

    modport source (
        output valid, cmd, grid_address, grid_value, query_x, query_y, query_z,
        input  ready
    );
    modport sink (
        input  valid, cmd, grid_address, grid_value, query_x, query_y, query_z,
        output ready
    );
endinterface

FILE: hdl/tgi_out_if.sv
interface tgi_out_if;
    import tgi_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     status;
    logic [VAR_W-1:0]         var_index;
    logic signed [DATA_W-1:0] value;
    logic                     last;

    modport source (
        output valid, status, var_index, value, last,
        input  ready
    );
    modport sink (
        input  valid, status, var_index, value, last,
        output ready
    );
endinterface

FILE: hdl/tgi_ram.sv
module tgi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: hdl/tgi_div.sv
module tgi_div #(
    parameter int IDX_W = 5
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic [tgi_pkg::DATA_W+IDX_W-1:0]        num,
    input  logic [tgi_pkg::DATA_W-1:0]              den,
    output logic [IDX_W+tgi_pkg::FRAC_W-1:0]        quot,
    output logic                                    busy
);
    import tgi_pkg::*;

    localparam int QW  = IDX_W + FRAC_W;
    localparam int CNW = $clog2(QW + 1);

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [QW-1:0]     sh_reg, sh_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic [CNW-1:0]    cnt_reg, cnt_next;
    logic [DATA_W:0]   trial;
    logic              ge;

    always_comb
    begin
        trial    = {rem_reg, sh_reg[QW-1]};
        ge       = trial >= {1'b0, den_reg};
        rem_next = rem_reg;
        sh_next  = sh_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = num[DATA_W+IDX_W-1:IDX_W];
            sh_next  = {num[IDX_W-1:0], {FRAC_W{1'b0}}};
            den_next = den;
            cnt_next = CNW'(QW);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = ge ? DATA_W'(trial - {1'b0, den_reg}) : trial[DATA_W-1:0];
            sh_next  = {sh_reg[QW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        den_reg <= den_next;
    end

    assign quot = sh_reg;
    assign busy = (cnt_reg != '0);

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && den_reg != '0) |-> rem_reg < den_reg)
        else $error("partial remainder not below divisor");
    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !start) |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("iteration count skipped");
    a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> cnt_reg == CNW'(QW))
        else $error("start did not load iteration count");
endmodule

FILE: hdl/trilinear_grid_interpolator_top.sv
// Trilinear interpolation over a regular 3-D grid held in a 2^18-word single-port
// memory. A write item (cmd 0) stores one grid word. A query item (cmd 1) checks
// bounds, then locates the cell (one restoring divider per axis, one quotient bit
// a cycle) and then reads the eight corners of each output variable, which share
// the single memory port. The default grid is 32x32x32 with 8 variables; results
// leave through a six-stage lerp pipeline and an output register. Reads of grid
// words never written return undefined values.
module trilinear_grid_interpolator_top #(
    parameter int POINTS_X = tgi_pkg::POINTS_X_DEF,
    parameter int POINTS_Y = tgi_pkg::POINTS_Y_DEF,
    parameter int POINTS_Z = tgi_pkg::POINTS_Z_DEF,
    parameter int NUM_VARS = tgi_pkg::NUM_VARS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tgi_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tgi_pkg::DATA_W-1:0]         cfg_data,
    tgi_in_if.sink                             in_ch,
    tgi_out_if.source                          out_ch
);
    import tgi_pkg::*;

    localparam int PMAX_XY = (POINTS_X > POINTS_Y) ? POINTS_X : POINTS_Y;
    localparam int PMAX    = (PMAX_XY > POINTS_Z) ? PMAX_XY : POINTS_Z;
    localparam int IW      = $clog2(PMAX);
    localparam int QW      = IW + FRAC_W;
    localparam int PTS [3] = '{POINTS_X, POINTS_Y, POINTS_Z};

    localparam logic [STORE_AW-1:0] PX_C  = STORE_AW'(POINTS_X);
    localparam logic [STORE_AW-1:0] PY_C  = STORE_AW'(POINTS_Y);
    localparam logic [STORE_AW-1:0] NV_C  = STORE_AW'(NUM_VARS);
    localparam logic [STORE_AW-1:0] OFF_X = STORE_AW'(NUM_VARS);
    localparam logic [STORE_AW-1:0] OFF_Y = STORE_AW'(POINTS_X * NUM_VARS);
    localparam logic [STORE_AW-1:0] OFF_Z = STORE_AW'(POINTS_X * POINTS_Y * NUM_VARS);

    localparam logic [VAR_W-1:0] VAR_FIRST   = VAR_W'(3);
    localparam logic [VAR_W-1:0] VAR_LAST    = VAR_W'(NUM_VARS - 1);
    localparam logic [VAR_W-1:0] VAR_ZERO    = VAR_W'(NUM_VARS - 3);
    localparam logic [2:0]       CORNER_LAST = 3'd7;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_OOB  = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_DST  = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_AD0  = 4'd6;
    localparam logic [3:0] S_AD1  = 4'd7;
    localparam logic [3:0] S_AD2  = 4'd8;
    localparam logic [3:0] S_RD   = 4'd9;
    localparam logic [3:0] S_WAIT = 4'd10;
    localparam logic [3:0] S_ZERO = 4'd11;

    logic signed [DATA_W-1:0] lo_reg [3];
    logic signed [DATA_W-1:0] hi_reg [3];
    logic                     append_reg;

    logic [3:0]               state_reg, state_next;
    logic signed [DATA_W-1:0] q_reg [3];
    logic                     oob_reg;
    logic [DATA_W+IW-1:0]     num_reg [3];
    logic [DATA_W-1:0]        range_reg [3];
    logic                     rz_reg [3];
    logic [QW-1:0]            quot [3];
    logic [2:0]               div_busy;
    logic [IW-1:0]            idx_reg [3];
    logic [IW-1:0]            idx_calc [3];
    logic [WGT_W-1:0]         w_reg [3];
    logic [WGT_W-1:0]         w_calc [3];
    logic [STORE_AW-1:0]      nz_reg, ny_reg, base_reg;
    logic [VAR_W-1:0]         var_reg, var_next;
    logic [2:0]               corner_reg, corner_next;

    logic                     in_acc;
    logic                     oob_in;
    logic                     ram_we;
    logic [STORE_AW-1:0]      ram_addr, rd_addr;
    logic [DATA_W-1:0]        ram_rdata;
    logic                     rd_valid_reg;
    logic [2:0]               rd_corner_reg;
    logic signed [DATA_W-1:0] cv_reg [8];
    logic                     full_reg;

    logic                     pipe_en;
    logic                     launch;
    meta_t                    launch_meta;

    logic                     v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    meta_t                    m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg;
    logic signed [PROD_W-1:0] px_reg [4];
    logic signed [DATA_W-1:0] ax_reg [4];
    logic signed [DATA_W-1:0] xl_reg [4];
    logic signed [PROD_W-1:0] py_reg [2];
    logic signed [DATA_W-1:0] ay_reg [2];
    logic signed [DATA_W-1:0] yl_reg [2];
    logic signed [PROD_W-1:0] pz_reg;
    logic signed [DATA_W-1:0] az_reg;
    logic signed [DATA_W-1:0] zl_reg;
    logic [WGT_W-1:0]         wy1_reg, wy2_reg;
    logic [WGT_W-1:0]         wz1_reg, wz2_reg, wz3_reg, wz4_reg;

    logic                     out_valid_reg;
    meta_t                    out_meta_reg;
    logic signed [DATA_W-1:0] out_value_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                lo_reg[a] <= BOUND_LOW_RST;
                hi_reg[a] <= BOUND_HIGH_RST;
            end
            append_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_X_LOW:  lo_reg[0] <= cfg_data;
                REG_X_HIGH: hi_reg[0] <= cfg_data;
                REG_Y_LOW:  lo_reg[1] <= cfg_data;
                REG_Y_HIGH: hi_reg[1] <= cfg_data;
                REG_Z_LOW:  lo_reg[2] <= cfg_data;
                REG_Z_HIGH: hi_reg[2] <= cfg_data;
                REG_APPEND: append_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign pipe_en     = !out_valid_reg || out_ch.ready;

    assign oob_in = (in_ch.query_x < lo_reg[0]) || (in_ch.query_x > hi_reg[0]) ||
                    (in_ch.query_y < lo_reg[1]) || (in_ch.query_y > hi_reg[1]) ||
                    (in_ch.query_z < lo_reg[2]) || (in_ch.query_z > hi_reg[2]);

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            q_reg[0] <= in_ch.query_x;
            q_reg[1] <= in_ch.query_y;
            q_reg[2] <= in_ch.query_z;
            oob_reg  <= oob_in;
        end
    end

    // per-axis cell location
    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        localparam logic [IW-1:0] PM1 = IW'(PTS[a] - 1);
        localparam logic [IW-1:0] PM2 = IW'(PTS[a] - 2);

        logic [DATA_W:0]  diff;
        logic [IW-1:0]    ival;
        logic [QW-1:0]    wcap;

        assign diff = (DATA_W+1)'(q_reg[a]) - (DATA_W+1)'(lo_reg[a]);
        assign ival = quot[a][QW-1:FRAC_W];
        assign wcap = quot[a] - {PM2, {FRAC_W{1'b0}}};

        always_comb
        begin
            if (rz_reg[a])
            begin
                idx_calc[a] = '0;
                w_calc[a]   = '0;
            end
            else if (ival > PM2)
            begin
                idx_calc[a] = PM2;
                w_calc[a]   = wcap[WGT_W-1:0];
            end
            else
            begin
                idx_calc[a] = ival;
                w_calc[a]   = {1'b0, quot[a][FRAC_W-1:0]};
            end
        end

        always_ff @(posedge clk)
        begin
            if (state_reg == S_MUL)
            begin
                num_reg[a]   <= (DATA_W+IW)'(diff[DATA_W-1:0]) * (DATA_W+IW)'(PM1);
                range_reg[a] <= DATA_W'(hi_reg[a] - lo_reg[a]);
                rz_reg[a]    <= (hi_reg[a] == lo_reg[a]);
            end
            if (state_reg == S_DIV && div_busy == '0)
            begin
                idx_reg[a] <= idx_calc[a];
                w_reg[a]   <= w_calc[a];
            end
        end

        tgi_div #(
            .IDX_W (IW)
        ) u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .start (state_reg == S_DST),
            .num   (num_reg[a]),
            .den   (range_reg[a]),
            .quot  (quot[a]),
            .busy  (div_busy[a])
        );
    end

    // node address
    always_ff @(posedge clk)
    begin
        if (state_reg == S_AD0)
        begin
            nz_reg <= STORE_AW'(idx_reg[2] * PY_C);
        end
        if (state_reg == S_AD1)
        begin
            ny_reg <= STORE_AW'((nz_reg + STORE_AW'(idx_reg[1])) * PX_C);
        end
        if (state_reg == S_AD2)
        begin
            base_reg <= STORE_AW'((ny_reg + STORE_AW'(idx_reg[0])) * NV_C);
        end
    end

    assign rd_addr = base_reg
                   + (corner_reg[0] ? OFF_X : '0)
                   + (corner_reg[1] ? OFF_Y : '0)
                   + (corner_reg[2] ? OFF_Z : '0)
                   + STORE_AW'(var_reg);

    assign ram_we   = in_acc && (in_ch.cmd == CMD_WRITE);
    assign ram_addr = (state_reg == S_IDLE) ? in_ch.grid_address : rd_addr;

    tgi_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_ch.grid_value),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        var_next    = var_reg;
        corner_next = corner_reg;
        launch      = 1'b0;
        launch_meta = '{status: STATUS_OK, var_index: var_reg - VAR_FIRST,
                        last: (var_reg == VAR_LAST) && !append_reg, zero: 1'b0};
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && in_ch.cmd == CMD_QUERY)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:  state_next = oob_reg ? S_OOB : S_MUL;
            S_OOB:
            begin
                launch_meta = '{status: STATUS_OOB, var_index: '0, last: 1'b1, zero: 1'b1};
                if (pipe_en)
                begin
                    launch     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MUL:  state_next = S_DST;
            S_DST:  state_next = S_DIV;
            S_DIV:
            begin
                if (div_busy == '0)
                begin
                    state_next = S_AD0;
                end
            end
            S_AD0:  state_next = S_AD1;
            S_AD1:  state_next = S_AD2;
            S_AD2:
            begin
                state_next  = S_RD;
                var_next    = VAR_FIRST;
                corner_next = '0;
            end
            S_RD:
            begin
                corner_next = corner_reg + 1'b1;
                if (corner_reg == CORNER_LAST)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (full_reg && pipe_en)
                begin
                    launch = 1'b1;
                    if (var_reg == VAR_LAST)
                    begin
                        state_next = append_reg ? S_ZERO : S_IDLE;
                    end
                    else
                    begin
                        var_next    = var_reg + 1'b1;
                        corner_next = '0;
                        state_next  = S_RD;
                    end
                end
            end
            S_ZERO:
            begin
                launch_meta = '{status: STATUS_OK, var_index: VAR_ZERO, last: 1'b1, zero: 1'b1};
                if (pipe_en)
                begin
                    launch     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            var_reg      <= '0;
            corner_reg   <= '0;
            rd_valid_reg <= 1'b0;
            full_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            var_reg      <= var_next;
            corner_reg   <= corner_next;
            rd_valid_reg <= (state_reg == S_RD);
            if (rd_valid_reg && rd_corner_reg == CORNER_LAST)
            begin
                full_reg <= 1'b1;
            end
            else if (launch)
            begin
                full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_corner_reg <= corner_reg;
        if (rd_valid_reg)
        begin
            cv_reg[rd_corner_reg] <= ram_rdata;
        end
    end

    // lerp pipeline: x, then y, then z
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            v1_reg        <= launch;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            out_valid_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            m1_reg  <= launch_meta;
            wy1_reg <= w_reg[1];
            wz1_reg <= w_reg[2];
            for (int k = 0; k < 4; k++)
            begin
                px_reg[k] <= lerp_mul(cv_reg[2*k], cv_reg[2*k+1], w_reg[0]);
                ax_reg[k] <= cv_reg[2*k];
            end

            m2_reg  <= m1_reg;
            wy2_reg <= wy1_reg;
            wz2_reg <= wz1_reg;
            for (int k = 0; k < 4; k++)
            begin
                xl_reg[k] <= lerp_add(ax_reg[k], px_reg[k]);
            end

            m3_reg  <= m2_reg;
            wz3_reg <= wz2_reg;
            for (int m = 0; m < 2; m++)
            begin
                py_reg[m] <= lerp_mul(xl_reg[2*m], xl_reg[2*m+1], wy2_reg);
                ay_reg[m] <= xl_reg[2*m];
            end

            m4_reg  <= m3_reg;
            wz4_reg <= wz3_reg;
            for (int m = 0; m < 2; m++)
            begin
                yl_reg[m] <= lerp_add(ay_reg[m], py_reg[m]);
            end

            m5_reg <= m4_reg;
            pz_reg <= lerp_mul(yl_reg[0], yl_reg[1], wz4_reg);
            az_reg <= yl_reg[0];

            m6_reg <= m5_reg;
            zl_reg <= lerp_add(az_reg, pz_reg);

            out_meta_reg  <= m6_reg;
            out_value_reg <= m6_reg.zero ? '0 : zl_reg;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.status    = out_meta_reg.status;
    assign out_ch.var_index = out_meta_reg.var_index;
    assign out_ch.value     = out_value_reg;
    assign out_ch.last      = out_meta_reg.last;

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_AD0) |->
            (idx_reg[0] <= IW'(POINTS_X - 2)) && (idx_reg[1] <= IW'(POINTS_Y - 2)) &&
            (idx_reg[2] <= IW'(POINTS_Z - 2)))
        else $error("cell index beyond grid");
    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_AD0) |->
            (w_reg[0] <= WGT_W'(1 << FRAC_W)) && (w_reg[1] <= WGT_W'(1 << FRAC_W)) &&
            (w_reg[2] <= WGT_W'(1 << FRAC_W)))
        else $error("weight above one");
    a_oob_last: assert property (@(posedge clk) disable iff (!rst_n)
        (v6_reg && m6_reg.status == STATUS_OOB) |-> (m6_reg.last && m6_reg.zero))
        else $error("out-of-bounds item not single");
    a_launch_full: assert property (@(posedge clk) disable iff (!rst_n)
        (launch && state_reg == S_WAIT) |-> full_reg && !rd_valid_reg)
        else $error("launch before all corners captured");
endmodule
